// ===== sv/wcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the wall clock snapshot block.
// Used by the serial divider, serial multiplier, leap scanner and top level.
package wcs_pkg;

    // Item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SLEW = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    // One second in nanoseconds
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Serial divider: 64-bit dividend, one quotient bit per cycle
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    // Serial multiplier: 30-bit operands, one multiplier bit per cycle
    localparam int MUL_W     = 30;
    localparam int MUL_CNT_W = $clog2(MUL_W);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_W - 1);

    // Leap second steps, ascending, and the offset at the first step
    localparam int LEAP_KNOWN = 28;
    localparam int LEAP_IDX_W = $clog2(LEAP_KNOWN);
    localparam logic [5:0] LEAP_FIRST = 6'd10;
    localparam logic [31:0] LEAP_AT [LEAP_KNOWN] = '{
        32'd63072000,   32'd78796800,   32'd94694400,   32'd126230400,
        32'd157766400,  32'd189302400,  32'd220924800,  32'd252460800,
        32'd283996800,  32'd315532800,  32'd362793600,  32'd394329600,
        32'd425865600,  32'd489024000,  32'd567993600,  32'd631152000,
        32'd662688000,  32'd709948800,  32'd741484800,  32'd773020800,
        32'd820454400,  32'd867715200,  32'd915148800,  32'd1136073600,
        32'd1230768000, 32'd1341100800, 32'd1435708800, 32'd1483228800
    };

    // Status of an iterative unit: busy while stepping, done for one cycle
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== sv/wall_clock_snapshot_with_leap.sv =====
`timescale 1ns / 1ps
// Top level of the wall clock snapshot: sequencer, clock state, result register.
// Depends on wcs_pkg, wcs_sdiv, wcs_smul and wcs_leap.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  mode, tick_count, slew_ns, target_sec
//   out      out_valid/out_ready  rt_sec, rt_nsec, up_sec, up_nsec, leap_secs
//
// A tick item runs three serial divides (ticks by TICK_HZ, sub-second product by
// one second, slew offset by one second), a serial multiply and the sum and
// output steps; the leap scan overlaps them. A step item runs one divide; a
// set-offset item only loads the offset. Reset clears the epoch and offset.
// A tick result waits in the output register while the next item is taken; a
// later tick result waits for that slot.
module wall_clock_snapshot_with_leap #(
    parameter int unsigned TICK_HZ      = 1000,
    parameter int unsigned NS_EACH_TICK = 1000000,
    parameter int unsigned LEAP_ENTRIES = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [63:0]        tick_count,
    input  logic signed [63:0] slew_ns,
    input  logic [63:0]        target_sec,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] rt_sec,
    output logic [29:0]        rt_nsec,
    output logic [63:0]        up_sec,
    output logic [29:0]        up_nsec,
    output logic [5:0]         leap_secs
);
    import wcs_pkg::*;

    localparam logic [29:0] TICK_DIV = 30'(TICK_HZ);
    localparam logic [29:0] NS_MUL   = 30'(NS_EACH_TICK);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV_T = 8'b0000_0010,
        ST_STEP  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_DIV_S = 8'b0001_0000,
        ST_DIV_O = 8'b0010_0000,
        ST_SUM   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        step_reg, step_next;
    logic [63:0] target_reg, target_next;
    logic [63:0] boot_reg, boot_next;
    logic [63:0] slew_reg, slew_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic [63:0] monos_reg, monos_next;
    logic [29:0] monons_reg, monons_next;
    logic [63:0] offq_reg, offq_next;
    logic [29:0] offr_reg, offr_next;
    logic [63:0] real_reg, real_next;
    logic [30:0] ns_reg, ns_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] orsec_reg, orsec_next;
    logic [29:0] orns_reg, orns_next;
    logic [63:0] omsec_reg, omsec_next;
    logic [29:0] omns_reg, omns_next;
    logic [5:0]  oleap_reg, oleap_next;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [29:0] div_divisor;
    logic [63:0] div_q;
    logic [29:0] div_r;
    unit_stat_t  div_stat;
    logic        mul_start;
    logic [59:0] mul_p;
    unit_stat_t  mul_stat;
    logic        leap_start;
    logic [63:0] leap_epoch;
    logic [5:0]  leap_val;
    unit_stat_t  leap_stat;

    logic        in_fire;
    logic        slew_neg;
    logic        rem_nz;
    logic        ns_carry;
    logic        slot_free;

    wcs_sdiv u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    wcs_smul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (NS_MUL),
        .mplier  (div_r),
        .product (mul_p),
        .stat    (mul_stat)
    );

    wcs_leap #(
        .LEAP_ENTRIES (LEAP_ENTRIES)
    ) u_leap (
        .clk   (clk),
        .rst_n (rst_n),
        .start (leap_start),
        .epoch (leap_epoch),
        .leap  (leap_val),
        .stat  (leap_stat)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign slew_neg   = slew_reg[63];
    assign rem_nz     = (div_r != 30'd0);
    assign ns_carry   = (ns_reg >= {1'b0, NS_PER_SEC});
    assign slot_free  = !ovalid_reg || out_ready;
    assign leap_epoch = boot_reg + div_q;

    // Sequence one item through the shared units
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        target_next  = target_reg;
        boot_next    = boot_reg;
        slew_next    = slew_reg;
        elapsed_next = elapsed_reg;
        monos_next   = monos_reg;
        monons_next  = monons_reg;
        offq_next    = offq_reg;
        offr_next    = offr_reg;
        real_next    = real_reg;
        ns_next      = ns_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        orsec_next   = orsec_reg;
        orns_next    = orns_reg;
        omsec_next   = omsec_reg;
        omns_next    = omns_reg;
        oleap_next   = oleap_reg;
        div_start    = 1'b0;
        div_dividend = tick_count;
        div_divisor  = TICK_DIV;
        mul_start    = 1'b0;
        leap_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    target_next = target_sec;
                    step_next   = (mode == MODE_STEP);
                    if (mode == MODE_SLEW)
                    begin
                        slew_next = slew_ns;
                    end
                    else if (mode == MODE_TICK || mode == MODE_STEP)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_T;
                    end
                end
            end
            ST_DIV_T:
            begin
                if (div_stat.done)
                begin
                    elapsed_next = div_q;
                    if (step_reg)
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        leap_start = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_STEP:
            begin
                // rebase the epoch, clamp at zero, drop the offset
                boot_next  = (target_reg >= elapsed_reg) ? (target_reg - elapsed_reg) : 64'd0;
                slew_next  = '0;
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    div_start    = 1'b1;
                    div_dividend = {4'd0, mul_p};
                    div_divisor  = NS_PER_SEC;
                    state_next   = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                if (div_stat.done)
                begin
                    monos_next   = elapsed_reg + div_q;
                    monons_next  = div_r;
                    div_start    = 1'b1;
                    div_dividend = slew_neg ? (64'd0 - slew_reg) : slew_reg;
                    div_divisor  = NS_PER_SEC;
                    state_next   = ST_DIV_O;
                end
            end
            ST_DIV_O:
            begin
                if (div_stat.done)
                begin
                    // floor the signed offset: -(q + 1) is ~q
                    if (!slew_neg)
                    begin
                        offq_next = div_q;
                        offr_next = div_r;
                    end
                    else if (rem_nz)
                    begin
                        offq_next = ~div_q;
                        offr_next = NS_PER_SEC - div_r;
                    end
                    else
                    begin
                        offq_next = 64'd0 - div_q;
                        offr_next = div_r;
                    end
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                real_next  = boot_reg + monos_reg;
                ns_next    = {1'b0, monons_reg} + {1'b0, offr_reg};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (slot_free && !leap_stat.busy)
                begin
                    orsec_next  = real_reg + offq_reg + {63'd0, ns_carry};
                    orns_next   = ns_carry ? 30'(ns_reg - {1'b0, NS_PER_SEC}) : ns_reg[29:0];
                    omsec_next  = monos_reg;
                    omns_next   = monons_reg;
                    oleap_next  = leap_val;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the datapath and the result payload
    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        target_reg  <= target_next;
        elapsed_reg <= elapsed_next;
        monos_reg   <= monos_next;
        monons_reg  <= monons_next;
        offq_reg    <= offq_next;
        offr_reg    <= offr_next;
        real_reg    <= real_next;
        ns_reg      <= ns_next;
        orsec_reg   <= orsec_next;
        orns_reg    <= orns_next;
        omsec_reg   <= omsec_next;
        omns_reg    <= omns_next;
        oleap_reg   <= oleap_next;
    end

    // Advance control state and the clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            boot_reg   <= '0;
            slew_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            boot_reg   <= boot_next;
            slew_reg   <= slew_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign rt_sec    = signed'(orsec_reg);
    assign rt_nsec   = orns_reg;
    assign up_sec    = omsec_reg;
    assign up_nsec   = omns_reg;
    assign leap_secs = oleap_reg;

    // The divider finishes only while the sequencer waits on it
    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_T || state_reg == ST_DIV_S ||
                           state_reg == ST_DIV_O))
        else $error("divider done outside a divide state");

    // The leap scan is over before the offset divide runs
    a_leap_early: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_O) |-> !leap_stat.busy)
        else $error("leap scan still busy during offset divide");

    // Nanosecond results are normalized
    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (orns_reg < NS_PER_SEC && omns_reg < NS_PER_SEC))
        else $error("nanoseconds out of range");

    // A time step clears the slew offset
    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |=> (slew_reg == 64'd0))
        else $error("slew offset kept across a step");

endmodule

// ===== sv/wcs_sdiv.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: 64-bit dividend by a divisor below 2^30.
// Depends on wcs_pkg.
module wcs_sdiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        dividend,
    input  logic [29:0]        divisor,
    output logic [63:0]        quotient,
    output logic [29:0]        remainder,
    output wcs_pkg::unit_stat_t stat
);
    import wcs_pkg::*;

    logic [63:0]          q_reg, q_next;
    logic [29:0]          r_reg, r_next;
    logic [29:0]          d_reg, d_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [30:0]          trial;
    logic [30:0]          diff;
    logic                 fits;

    // Shift one dividend bit into the partial remainder, subtract when it fits
    always_comb
    begin
        trial     = {r_reg, q_reg[63]};
        diff      = trial - {1'b0, d_reg};
        fits      = (trial >= {1'b0, d_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[62:0], fits};
            r_next   = fits ? diff[29:0] : trial[29:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

// ===== sv/wcs_smul.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-and-add multiplier, 30 by 30 bits, multiplier MSB first.
// Depends on wcs_pkg.
module wcs_smul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [29:0]        mcand,
    input  logic [29:0]        mplier,
    output logic [59:0]        product,
    output wcs_pkg::unit_stat_t stat
);
    import wcs_pkg::*;

    logic [59:0]          acc_reg, acc_next;
    logic [29:0]          a_reg, a_next;
    logic [29:0]          b_reg, b_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Double the sum and add the multiplicand when the next bit is set
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = mplier;
            b_next    = mcand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[58:0], 1'b0} + (a_reg[29] ? {30'd0, b_reg} : 60'd0);
            a_next   = {a_reg[28:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign product = acc_reg;
    assign stat    = '{busy: busy_reg, done: done_reg};

endmodule

// ===== sv/wcs_leap.sv =====
`timescale 1ns / 1ps
// Leap offset scanner: walks the ascending leap step table one entry a cycle.
// Depends on wcs_pkg for the table and the unit status type.
module wcs_leap #(
    parameter int unsigned LEAP_ENTRIES = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        epoch,
    output logic [5:0]         leap,
    output wcs_pkg::unit_stat_t stat
);
    import wcs_pkg::*;

    localparam int SCAN_N = (LEAP_ENTRIES < LEAP_KNOWN) ? LEAP_ENTRIES : LEAP_KNOWN;
    localparam logic [LEAP_IDX_W-1:0] SCAN_LAST = LEAP_IDX_W'(SCAN_N - 1);

    logic [63:0]           epoch_reg, epoch_next;
    logic [5:0]            val_reg, val_next;
    logic [LEAP_IDX_W-1:0] idx_reg, idx_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // Take the offset of every step the epoch has reached
    always_comb
    begin
        epoch_next = epoch_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            epoch_next = epoch;
            val_next   = '0;
            idx_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (epoch_reg >= {32'd0, LEAP_AT[idx_reg]})
            begin
                val_next = LEAP_FIRST + {{(6 - LEAP_IDX_W){1'b0}}, idx_reg};
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == SCAN_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold the epoch and the running offset
    always_ff @(posedge clk)
    begin
        epoch_reg <= epoch_next;
        val_reg   <= val_next;
    end

    // Advance the table index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign leap = val_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// ===== tb/wall_clock_snapshot_with_leap_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wall_clock_snapshot_with_leap: directed rows, then random items.
// Depends on wcs_pkg for the mode codes; keeps its own clock state to predict each snapshot.
module wall_clock_snapshot_with_leap_tb;
    import wcs_pkg::MODE_TICK;
    import wcs_pkg::MODE_SLEW;
    import wcs_pkg::MODE_STEP;

    localparam int unsigned TICK_HZ      = 1000;
    localparam int unsigned NS_EACH_TICK = 1000000;
    localparam int unsigned LEAP_ENTRIES = 28;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [63:0] HZ64        = 64'(TICK_HZ);
    localparam logic [63:0] NS_TICK64   = 64'(NS_EACH_TICK);
    localparam logic [63:0] SEC64       = 64'd1000000000;
    localparam int          LEAP_STEPS  = 28;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 2000;
    localparam int          SETTLE      = 400;
    localparam int          PHASE_ITEMS = 120;

    // Epoch seconds at which each leap step takes effect; offset is 10 plus the index
    localparam logic [63:0] LEAP_STEP_SEC [LEAP_STEPS] = '{
        64'd63072000,   64'd78796800,   64'd94694400,   64'd126230400,
        64'd157766400,  64'd189302400,  64'd220924800,  64'd252460800,
        64'd283996800,  64'd315532800,  64'd362793600,  64'd394329600,
        64'd425865600,  64'd489024000,  64'd567993600,  64'd631152000,
        64'd662688000,  64'd709948800,  64'd741484800,  64'd773020800,
        64'd820454400,  64'd867715200,  64'd915148800,  64'd1136073600,
        64'd1230768000, 64'd1341100800, 64'd1435708800, 64'd1483228800
    };

    typedef struct packed {
        logic signed [63:0] rt_sec;
        logic [29:0]        rt_nsec;
        logic [63:0]        up_sec;
        logic [29:0]        up_nsec;
        logic [5:0]         leap_secs;
    } snap_t;

    typedef struct {
        logic [1:0]  mode;
        logic [63:0] ticks;
        logic [63:0] slew;
        logic [63:0] target;
        bit          typed;
        snap_t       want;
    } clock_item_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [63:0]        tick_count;
    logic signed [63:0] slew_ns;
    logic [63:0]        target_sec;
    logic               out_valid;
    logic               out_ready;
    logic signed [63:0] rt_sec;
    logic [29:0]        rt_nsec;
    logic [63:0]        up_sec;
    logic [29:0]        up_nsec;
    logic [5:0]         leap_secs;

    // Predicted clock state, advanced as items are accepted
    logic [63:0] base_sec;
    logic [63:0] slew_off_ns;

    snap_t       snap_queue [$];
    clock_item_t plan [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request = 1'b0;

    wall_clock_snapshot_with_leap #(
        .TICK_HZ     (TICK_HZ),
        .NS_EACH_TICK(NS_EACH_TICK),
        .LEAP_ENTRIES(LEAP_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .tick_count(tick_count),
        .slew_ns   (slew_ns),
        .target_sec(target_sec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rt_sec    (rt_sec),
        .rt_nsec   (rt_nsec),
        .up_sec    (up_sec),
        .up_nsec   (up_nsec),
        .leap_secs (leap_secs)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Compute the snapshot a tick item should return from the current clock state
    function automatic snap_t take_snapshot(logic [63:0] ticks);
        logic [63:0] whole_sec;
        logic [63:0] sub_ns;
        logic [63:0] mono_s;
        logic [63:0] mono_ns;
        logic [63:0] mag;
        logic [63:0] off_s;
        logic [63:0] off_ns;
        logic [63:0] sum_s;
        logic [63:0] sum_ns;
        logic [63:0] unslewed;
        int          n;
        snap_t       s;
        whole_sec = ticks / HZ64;
        sub_ns    = (ticks % HZ64) * NS_TICK64;
        mono_s    = whole_sec + sub_ns / SEC64;
        mono_ns   = sub_ns % SEC64;
        // floor the signed offset to whole seconds, remainder kept positive
        if (slew_off_ns[63])
        begin
            mag    = -slew_off_ns;
            off_s  = mag / SEC64;
            off_ns = mag % SEC64;
            if (off_ns != 0)
            begin
                off_s  = off_s + 1;
                off_ns = SEC64 - off_ns;
            end
            off_s = -off_s;
        end
        else
        begin
            off_s  = slew_off_ns / SEC64;
            off_ns = slew_off_ns % SEC64;
        end
        sum_s  = base_sec + mono_s + off_s;
        sum_ns = mono_ns + off_ns;
        if (sum_ns >= SEC64)
        begin
            sum_ns = sum_ns - SEC64;
            sum_s  = sum_s + 1;
        end
        // scan the ascending leap steps at the unslewed epoch
        unslewed    = base_sec + whole_sec;
        s.leap_secs = 6'd0;
        n = (LEAP_ENTRIES < LEAP_STEPS) ? int'(LEAP_ENTRIES) : LEAP_STEPS;
        for (int i = 0; i < n; i++)
        begin
            if (unslewed < LEAP_STEP_SEC[i])
                break;
            s.leap_secs = 6'(10 + i);
        end
        s.rt_sec  = sum_s;
        s.rt_nsec = sum_ns[29:0];
        s.up_sec  = mono_s;
        s.up_nsec = mono_ns[29:0];
        return s;
    endfunction

    function automatic clock_item_t plan_row(logic [1:0] m, logic [63:0] tc, logic [63:0] sl,
                                             logic [63:0] tg, bit typed, snap_t want);
        clock_item_t it;
        it.mode   = m;
        it.ticks  = tc;
        it.slew   = sl;
        it.target = tg;
        it.typed  = typed;
        it.want   = want;
        return it;
    endfunction

    // Draw one random item, biased toward leap boundaries and small tick counts
    function automatic clock_item_t draw_item();
        clock_item_t it;
        int          pick;
        longint      whole;
        it.typed  = 1'b0;
        it.want   = '0;
        it.ticks  = {$urandom, $urandom};
        it.slew   = {$urandom, $urandom};
        it.target = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 56)
            it.mode = MODE_TICK;
        else if (pick < 76)
            it.mode = MODE_SLEW;
        else if (pick < 94)
            it.mode = MODE_STEP;
        else
            it.mode = MODE_UNUSED;
        case ($urandom_range(9))
            0, 1: ;
            2: it.ticks = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
            3: it.ticks = 64'($urandom);
            default: it.ticks = 64'($urandom_range(0, 20000));
        endcase
        case ($urandom_range(7))
            0: ;
            1:
            begin
                case ($urandom_range(3))
                    0: it.slew = 64'h7FFF_FFFF_FFFF_FFFF;
                    1: it.slew = 64'h8000_0000_0000_0000;
                    2: it.slew = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: it.slew = 64'd0;
                endcase
            end
            2, 3:
            begin
                whole   = (longint'($urandom_range(0, 8)) - 4) * 64'sd1000000000;
                it.slew = whole + longint'($urandom_range(0, 2)) - 1;
            end
            default: it.slew = 64'($signed($urandom));
        endcase
        case ($urandom_range(5))
            0: ;
            1: it.target = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
            2: it.target = 64'($urandom_range(0, 30));
            default: it.target = LEAP_STEP_SEC[$urandom_range(LEAP_STEPS - 1)]
                                 + 64'($urandom_range(0, 30)) - 64'd15;
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item, hold it until taken, then advance the predicted state
    task automatic offer_item(input clock_item_t it);
        logic [63:0] whole_sec;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= it.mode;
        tick_count <= it.ticks;
        slew_ns    <= it.slew;
        target_sec <= it.target;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (it.mode)
            MODE_TICK: snap_queue.push_back(it.typed ? it.want : take_snapshot(it.ticks));
            MODE_SLEW: slew_off_ns = it.slew;
            MODE_STEP:
            begin
                whole_sec   = it.ticks / HZ64;
                base_sec    = (it.target >= whole_sec) ? it.target - whole_sec : 64'd0;
                slew_off_ns = 64'd0;
            end
            default: ;
        endcase
    endtask

    // Drive out_ready: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request && !hold_done)
            begin
                stall_left = HOLD_CYCLES;
                hold_done  = 1'b1;
                out_ready  <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each taken result with the oldest expected snapshot
    always @(posedge clk)
    begin : check_results
        snap_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (snap_queue.size() == 0)
                report_mismatch("result with no tick item waiting", rt_sec, 64'd0);
            else
            begin
                want = snap_queue.pop_front();
                if (rt_sec !== want.rt_sec)
                    report_mismatch("rt_sec", rt_sec, want.rt_sec);
                if (rt_nsec !== want.rt_nsec)
                    report_mismatch("rt_nsec", rt_nsec, want.rt_nsec);
                if (up_sec !== want.up_sec)
                    report_mismatch("up_sec", up_sec, want.up_sec);
                if (up_nsec !== want.up_nsec)
                    report_mismatch("up_nsec", up_nsec, want.up_nsec);
                if (leap_secs !== want.leap_secs)
                    report_mismatch("leap_secs", leap_secs, want.leap_secs);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     snap_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int accepted;
        clock_item_t it;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_TICK;
        tick_count  = 64'd0;
        slew_ns     = 64'sd0;
        target_sec  = 64'd0;
        base_sec    = 64'd0;
        slew_off_ns = 64'd0;

        // Directed rows; typed expectations where the answer is plain
        plan.push_back(plan_row(MODE_TICK, 64'd0, 64'd0, 64'd0, 1'b1,
                                '{64'sd0, 30'd0, 64'd0, 30'd0, 6'd0}));
        plan.push_back(plan_row(MODE_TICK, 64'd1999, 64'd0, 64'd0, 1'b1,
                                '{64'sd1, 30'd999000000, 64'd1, 30'd999000000, 6'd0}));
        plan.push_back(plan_row(MODE_TICK, '1, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_UNUSED, '1, '1, '1, 1'b0, '0));
        plan.push_back(plan_row(MODE_SLEW, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd12345, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_SLEW, 64'd0, 64'h8000_0000_0000_0000, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, '1, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_SLEW, 64'd0, '1, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd0, 64'd0, 64'd0, 1'b1,
                                '{-64'sd1, 30'd999999999, 64'd0, 30'd0, 6'd0}));
        plan.push_back(plan_row(MODE_SLEW, 64'd0, 64'd1, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd999, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_STEP, 64'd10000, 64'd0, 64'd5, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd10000, 64'd0, 64'd0, 1'b1,
                                '{64'sd10, 30'd0, 64'd10, 30'd0, 6'd0}));
        plan.push_back(plan_row(MODE_STEP, 64'd0, 64'd0, 64'd63072000, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd0, 64'd0, 64'd0, 1'b1,
                                '{64'sd63072000, 30'd0, 64'd0, 30'd0, 6'd10}));
        plan.push_back(plan_row(MODE_STEP, 64'd0, 64'd0, 64'd63071999, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd999, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd1000, 64'd0, 64'd0, 1'b1,
                                '{64'sd63072000, 30'd0, 64'd1, 30'd0, 6'd10}));
        plan.push_back(plan_row(MODE_STEP, 64'd0, 64'd0, 64'd1483228800, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd0, 64'd0, 64'd0, 1'b1,
                                '{64'sd1483228800, 30'd0, 64'd0, 30'd0, 6'd37}));
        plan.push_back(plan_row(MODE_SLEW, 64'd0, -64'sd1500000000, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd2500, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_STEP, 64'd0, 64'd0, '1, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd5000, 64'd0, 64'd0, 1'b1,
                                '{64'sd4, 30'd0, 64'd5, 30'd0, 6'd0}));
        plan.push_back(plan_row(MODE_STEP, '1, 64'd0, 64'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 64'd7, 64'd0, 64'd0, 1'b0, '0));

        send_idle_pct = 32;
        recv_idle_pct = 74;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            offer_item(plan[k]);

        // Random items in three idling phases; long receiver hold-off in the last
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            accepted = 0;
            while (accepted < PHASE_ITEMS)
            begin
                it = draw_item();
                offer_item(it);
                if (it.mode != MODE_UNUSED)
                    accepted++;
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding snapshots, then watch for stray results
        while (snap_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wcs_pkg.sv
sv/wcs_sdiv.sv
sv/wcs_smul.sv
sv/wcs_leap.sv
sv/wall_clock_snapshot_with_leap.sv
tb/wall_clock_snapshot_with_leap_tb.sv
